/* rtl/usb_control_endpoint_responder_defines.svh */
// assertion macros shared by the responder
`ifndef USB_CONTROL_ENDPOINT_RESPONDER_DEFINES_SVH
`define USB_CONTROL_ENDPOINT_RESPONDER_DEFINES_SVH

// implication checked on every clock edge outside reset
`define UCER_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// implication whose consequence is checked in the cycle after the antecedent
`define UCER_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/ucer_pkg.sv */
package ucer_pkg;

  localparam int EP0_PACKET_BYTES_DEF     = 8;
  localparam int DESCRIPTOR_ROM_BYTES_DEF = 256;
  localparam int DESC_TABLE_BYTES         = 156;

  // event codes
  localparam logic [1:0] CMD_SETUP = 2'd0;
  localparam logic [1:0] CMD_IN    = 2'd1;
  localparam logic [1:0] CMD_OUT   = 2'd2;
  localparam logic [1:0] CMD_RESET = 2'd3;

  // handshake codes
  localparam logic [1:0] HS_ACK   = 2'd0;
  localparam logic [1:0] HS_NAK   = 2'd1;
  localparam logic [1:0] HS_STALL = 2'd2;

  // toggle actions
  localparam logic [1:0] TOG_KEEP  = 2'd0;
  localparam logic [1:0] TOG_DATA1 = 2'd1;
  localparam logic [1:0] TOG_FLIP  = 2'd2;

  // halt actions
  localparam logic [1:0] HALT_NONE  = 2'd0;
  localparam logic [1:0] HALT_SET   = 2'd1;
  localparam logic [1:0] HALT_CLEAR = 2'd2;

  // standard request codes, plus the class SET_REPORT code and an internal stalled marker
  localparam logic [7:0] REQ_GET_STATUS    = 8'h00;
  localparam logic [7:0] REQ_CLEAR_FEATURE = 8'h01;
  localparam logic [7:0] REQ_SET_FEATURE   = 8'h03;
  localparam logic [7:0] REQ_SET_ADDRESS   = 8'h05;
  localparam logic [7:0] REQ_GET_DESC      = 8'h06;
  localparam logic [7:0] REQ_GET_CONFIG    = 8'h08;
  localparam logic [7:0] REQ_SET_CONFIG    = 8'h09;
  localparam logic [7:0] REQ_GET_INTERFACE = 8'h0A;
  localparam logic [7:0] REQ_SET_REPORT    = 8'h09;
  localparam logic [7:0] REQ_STALLED       = 8'hFF;

  // descriptor types
  localparam logic [7:0] DT_DEVICE = 8'h01;
  localparam logic [7:0] DT_CONFIG = 8'h02;
  localparam logic [7:0] DT_STRING = 8'h03;
  localparam logic [7:0] DT_REPORT = 8'h22;

  // descriptor table offsets and lengths
  localparam logic [7:0] OFF_DEV   = 8'd0;
  localparam logic [7:0] OFF_CFG   = 8'd18;
  localparam logic [7:0] OFF_REP   = 8'd52;
  localparam logic [7:0] OFF_LANG  = 8'd86;
  localparam logic [7:0] OFF_MANUF = 8'd90;
  localparam logic [7:0] OFF_PROD  = 8'd112;
  localparam logic [7:0] OFF_SER   = 8'd142;
  localparam logic [7:0] LEN_DEV   = 8'd18;
  localparam logic [7:0] LEN_CFG   = 8'd34;
  localparam logic [7:0] LEN_REP   = 8'd34;
  localparam logic [7:0] LEN_LANG  = 8'd4;
  localparam logic [7:0] LEN_MANUF = 8'd22;
  localparam logic [7:0] LEN_PROD  = 8'd30;
  localparam logic [7:0] LEN_SER   = 8'd14;

  // byte of the device descriptor that carries the packet size
  localparam logic [7:0] DEV_MAXPKT_POS = 8'd7;

  localparam logic [7:0] DESC_TABLE [DESC_TABLE_BYTES] = '{
    8'h12,8'h01,8'h00,8'h02,8'h00,8'h00,8'h00,8'h08,
    8'hC0,8'h16,8'h52,8'h55,8'h00,8'h01,8'h01,8'h02,8'h03,8'h01,
    8'h09,8'h02,8'h22,8'h00,8'h01,8'h01,8'h00,8'h80,8'h32,
    8'h09,8'h04,8'h00,8'h00,8'h01,8'h03,8'h00,8'h00,8'h00,
    8'h09,8'h21,8'h11,8'h01,8'h00,8'h01,8'h22,8'h22,8'h00,
    8'h07,8'h05,8'h82,8'h03,8'h08,8'h00,8'h01,
    8'h06,8'h00,8'hFF,8'h09,8'h01,8'hA1,8'h01,
    8'h09,8'h02,8'h15,8'h00,8'h26,8'hFF,8'h00,8'h75,8'h08,8'h95,8'h08,8'h81,8'h02,
    8'h09,8'h03,8'h15,8'h00,8'h26,8'hFF,8'h00,8'h75,8'h08,8'h95,8'h08,8'h91,8'h02,
    8'hC0,
    8'h04,8'h03,8'h09,8'h04,
    8'h16,8'h03,8'h4A,8'h00,8'h6F,8'h00,8'h68,8'h00,8'h6E,8'h00,8'h6E,8'h00,
    8'h79,8'h00,8'h35,8'h00,8'h35,8'h00,8'h32,8'h00,8'h2E,8'h00,
    8'h1E,8'h03,8'h4A,8'h00,8'h6F,8'h00,8'h68,8'h00,8'h6E,8'h00,8'h6E,8'h00,
    8'h79,8'h00,8'h35,8'h00,8'h35,8'h00,8'h32,8'h00,
    8'h2D,8'h00,8'h43,8'h00,8'h6F,8'h00,8'h72,8'h00,8'h65,8'h00,
    8'h0E,8'h03,8'h76,8'h00,8'h31,8'h00,8'h2E,8'h00,8'h30,8'h00,8'h2E,8'h00,
    8'h30,8'h00
  };

  typedef struct packed {
    logic [1:0]  command;
    logic [6:0]  rx_length;
    logic        toggle_ok;
    logic [7:0]  request_type;
    logic [7:0]  request_code;
    logic [7:0]  value_low;
    logic [7:0]  value_high;
    logic [7:0]  index_low;
    logic [7:0]  index_high;
    logic [15:0] length_requested;
  } ucer_in_t;

  typedef struct packed {
    logic [1:0] handshake;
    logic [1:0] toggle_action;
    logic [3:0] packet_length;
    logic [7:0] data_byte;
    logic       last;
    logic [6:0] address_value;
    logic       address_write;
    logic [7:0] config_value;
    logic [1:0] halt_endpoint;
    logic       halt_direction;
    logic [1:0] halt_action;
  } ucer_out_t;

  // one decoded event, streamed out by the emitter
  typedef struct packed {
    logic [1:0] hs;
    logic [1:0] tog;
    logic [3:0] plen;
    logic [6:0] addr;
    logic       addr_wr;
    logic [7:0] cfg;
    logic [1:0] h_ep;
    logic       h_dir;
    logic [1:0] h_act;
    logic       from_rom;
    logic [7:0] imm;
    logic [7:0] cursor;
  } ucer_job_t;

  // packet size actually used on endpoint zero
  function automatic logic [3:0] pkt_bytes(input int ep0_bytes);
    pkt_bytes = (ep0_bytes > 8) ? 4'd8 : 4'(ep0_bytes);
  endfunction

endpackage

/* rtl/ucer_in_if.sv */
interface ucer_in_if;
  import ucer_pkg::*;
  logic     valid;
  logic     ready;
  ucer_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/ucer_out_if.sv */
interface ucer_out_if;
  import ucer_pkg::*;
  logic      valid;
  logic      ready;
  ucer_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/ucer_rom.sv */
module ucer_rom
  import ucer_pkg::*;
#(
  parameter int EP0_PACKET_BYTES     = EP0_PACKET_BYTES_DEF,
  parameter int DESCRIPTOR_ROM_BYTES = DESCRIPTOR_ROM_BYTES_DEF
) (
  input  logic       clk,
  input  logic [7:0] addr,
  output logic [7:0] rd_data_r
);

  localparam logic [3:0] PktBytes = pkt_bytes(EP0_PACKET_BYTES);

  logic [7:0] rom_nxt;

  // table lookup with the packet size patched in, zero past the table or the configured size
  always_comb begin
    rom_nxt = 8'd0;
    if ((32'(addr) < 32'(DESCRIPTOR_ROM_BYTES)) && (32'(addr) < 32'(DESC_TABLE_BYTES))) begin
      if (addr == DEV_MAXPKT_POS) begin
        rom_nxt = {4'd0, PktBytes};
      end else begin
        rom_nxt = DESC_TABLE[addr];
      end
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data_r <= rom_nxt;
  end

endmodule

/* rtl/ucer_ctrl.sv */
module ucer_ctrl
  import ucer_pkg::*;
#(
  parameter int EP0_PACKET_BYTES = EP0_PACKET_BYTES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      accept,
  input  ucer_in_t  item,
  output ucer_job_t job
);

  localparam logic [3:0] PktBytes = pkt_bytes(EP0_PACKET_BYTES);

  logic [7:0]  pending_request_r, pending_request_nxt;
  logic [15:0] remaining_bytes_r, remaining_bytes_nxt;
  logic [7:0]  descriptor_cursor_r, descriptor_cursor_nxt;
  logic [6:0]  pending_address_r, pending_address_nxt;
  logic [7:0]  configuration_r, configuration_nxt;

  logic        stall;
  logic [15:0] rem;
  logic [7:0]  off;
  logic [7:0]  dlen;
  logic        desc_ok;
  logic [3:0]  n;
  logic        halt_ok;
  logic        recip_ep;

  // endpoint index check for halt requests
  always_comb begin
    halt_ok = (item.index_low[6:2] == 5'd0) && (item.index_low[1:0] != 2'd0);
  end

  // descriptor lookup
  always_comb begin
    off     = OFF_DEV;
    dlen    = LEN_DEV;
    desc_ok = 1'b1;
    unique case (item.value_high)
      DT_DEVICE: begin
        off = OFF_DEV;  dlen = LEN_DEV;
      end
      DT_CONFIG: begin
        off = OFF_CFG;  dlen = LEN_CFG;
      end
      DT_REPORT: begin
        off = OFF_REP;  dlen = LEN_REP;
      end
      DT_STRING: begin
        if (item.value_low == 8'd0) begin
          off = OFF_LANG;  dlen = LEN_LANG;
        end else if (item.value_low == 8'd1) begin
          off = OFF_MANUF; dlen = LEN_MANUF;
        end else if (item.value_low == 8'd2) begin
          off = OFF_PROD;  dlen = LEN_PROD;
        end else begin
          off = OFF_SER;   dlen = LEN_SER;
        end
      end
      default: desc_ok = 1'b0;
    endcase
  end

  // event decode and next state
  always_comb begin
    pending_request_nxt   = pending_request_r;
    remaining_bytes_nxt   = remaining_bytes_r;
    descriptor_cursor_nxt = descriptor_cursor_r;
    pending_address_nxt   = pending_address_r;
    configuration_nxt     = configuration_r;
    job                   = '0;
    stall                 = 1'b0;
    rem                   = 16'd0;
    n                     = 4'd0;
    recip_ep              = (item.request_type[4:0] == 5'd2);

    unique case (item.command)
      CMD_SETUP: begin
        if (item.rx_length != 7'd8) begin
          stall = 1'b1;
        end else begin
          remaining_bytes_nxt = item.length_requested;
          pending_request_nxt = item.request_code;
          if (item.request_type[6:5] != 2'd0) begin
            stall = (item.request_code != REQ_SET_REPORT);
          end else begin
            unique case (item.request_code)
              REQ_GET_DESC: begin
                if (!desc_ok) begin
                  stall = 1'b1;
                end else begin
                  rem = (item.length_requested > {8'd0, dlen}) ? {8'd0, dlen}
                                                               : item.length_requested;
                  n = (rem >= {12'd0, PktBytes}) ? PktBytes : rem[3:0];
                  remaining_bytes_nxt   = rem - {12'd0, n};
                  descriptor_cursor_nxt = off + {4'd0, n};
                  job.cursor            = off;
                  job.from_rom          = 1'b1;
                end
              end
              REQ_SET_ADDRESS: pending_address_nxt = item.value_low[6:0];
              REQ_GET_CONFIG: begin
                job.imm = configuration_r;
                n = (item.length_requested != 16'd0) ? 4'd1 : 4'd0;
              end
              REQ_SET_CONFIG: configuration_nxt = item.value_low;
              REQ_GET_INTERFACE: n = 4'd0;
              REQ_CLEAR_FEATURE: begin
                if (recip_ep && halt_ok) begin
                  job.h_ep  = item.index_low[1:0];
                  job.h_dir = item.index_low[7];
                  job.h_act = HALT_CLEAR;
                end else begin
                  stall = 1'b1;
                end
              end
              REQ_SET_FEATURE: begin
                if (recip_ep && (item.value_low == 8'd0) && (item.value_high == 8'd0)
                    && (item.index_high == 8'd0) && halt_ok) begin
                  job.h_ep  = item.index_low[1:0];
                  job.h_dir = item.index_low[7];
                  job.h_act = HALT_SET;
                end else begin
                  stall = 1'b1;
                end
              end
              REQ_GET_STATUS: begin
                n = (item.length_requested >= 16'd2) ? 4'd2 : item.length_requested[3:0];
              end
              default: stall = 1'b1;
            endcase
          end
        end
        if (stall) begin
          pending_request_nxt = REQ_STALLED;
          job                 = '0;
          n                   = 4'd0;
          job.hs              = HS_STALL;
        end
        job.tog = TOG_DATA1;
      end
      CMD_IN: begin
        if (pending_request_r == REQ_GET_DESC) begin
          n = (remaining_bytes_r >= {12'd0, PktBytes}) ? PktBytes : remaining_bytes_r[3:0];
          remaining_bytes_nxt   = remaining_bytes_r - {12'd0, n};
          descriptor_cursor_nxt = descriptor_cursor_r + {4'd0, n};
          job.cursor            = descriptor_cursor_r;
          job.from_rom          = 1'b1;
          job.tog               = TOG_FLIP;
        end else if (pending_request_r == REQ_SET_ADDRESS) begin
          job.addr    = pending_address_r;
          job.addr_wr = 1'b1;
          job.hs      = HS_NAK;
        end else begin
          job.hs = HS_NAK;
        end
      end
      CMD_RESET: begin
        configuration_nxt = 8'd0;
        job.addr_wr       = 1'b1;
        job.hs            = HS_NAK;
      end
      default: ;
    endcase
    job.plen = n;
    job.cfg  = configuration_nxt;
  end

  // request state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_request_r   <= 8'd0;
      remaining_bytes_r   <= 16'd0;
      descriptor_cursor_r <= 8'd0;
      pending_address_r   <= 7'd0;
      configuration_r     <= 8'd0;
    end else if (accept) begin
      pending_request_r   <= pending_request_nxt;
      remaining_bytes_r   <= remaining_bytes_nxt;
      descriptor_cursor_r <= descriptor_cursor_nxt;
      pending_address_r   <= pending_address_nxt;
      configuration_r     <= configuration_nxt;
    end
  end

endmodule

/* rtl/usb_control_endpoint_responder.sv */
// Endpoint-zero responder. Each accepted transaction (setup, IN done, OUT done,
// bus reset) is decoded in the cycle it is taken and gives one result per byte
// of the next IN packet, or a single result when that packet is empty; the
// result stream runs at one per cycle while the receiver is ready, and the
// next transaction is taken in the cycle its predecessor's last result is
// loaded into the output register. Descriptor bytes come from a synchronous
// ROM addressed with the next job slot and byte index.
`include "usb_control_endpoint_responder_defines.svh"

module usb_control_endpoint_responder
  import ucer_pkg::*;
#(
  parameter int EP0_PACKET_BYTES     = EP0_PACKET_BYTES_DEF,
  parameter int DESCRIPTOR_ROM_BYTES = DESCRIPTOR_ROM_BYTES_DEF
) (
  input  logic clk,
  input  logic rst_n,
  ucer_in_if.sink    in_ch,
  ucer_out_if.source out_ch
);

  ucer_job_t  new_job;
  ucer_job_t  job_r, job_nxt;
  logic       job_valid_r, job_valid_nxt;
  logic [2:0] k_r, k_nxt;
  logic [2:0] cnt_m1;
  logic       emit;
  logic       emit_last;
  logic       accept;
  logic [7:0] rom_addr;
  logic [7:0] rom_q;
  logic [7:0] byte_val;
  logic       out_valid_r, out_valid_nxt;
  ucer_out_t  out_data_r, out_data_nxt;

  // handshakes
  assign cnt_m1       = (job_r.plen == 4'd0) ? 3'd0 : 3'(job_r.plen - 4'd1);
  assign emit         = job_valid_r && (!out_valid_r || out_ch.ready);
  assign emit_last    = emit && (k_r == cnt_m1);
  assign in_ch.ready  = !job_valid_r || emit_last;
  assign accept       = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  ucer_ctrl #(
    .EP0_PACKET_BYTES(EP0_PACKET_BYTES)
  ) u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .item   (in_ch.data),
    .job    (new_job)
  );

  // job slot and byte index
  always_comb begin
    job_nxt       = job_r;
    job_valid_nxt = job_valid_r;
    k_nxt         = k_r;
    if (accept) begin
      job_nxt       = new_job;
      job_valid_nxt = 1'b1;
      k_nxt         = 3'd0;
    end else if (emit_last) begin
      job_valid_nxt = 1'b0;
    end else if (emit) begin
      k_nxt = k_r + 3'd1;
    end
  end

  // fetch the byte the job will present next cycle
  assign rom_addr = job_nxt.cursor + {5'd0, k_nxt};

  ucer_rom #(
    .EP0_PACKET_BYTES     (EP0_PACKET_BYTES),
    .DESCRIPTOR_ROM_BYTES (DESCRIPTOR_ROM_BYTES)
  ) u_rom (
    .clk       (clk),
    .addr      (rom_addr),
    .rd_data_r (rom_q)
  );

  // result byte and output register
  always_comb begin
    if (job_r.plen == 4'd0) begin
      byte_val = 8'd0;
    end else if (job_r.from_rom) begin
      byte_val = rom_q;
    end else begin
      byte_val = (k_r == 3'd0) ? job_r.imm : 8'd0;
    end
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (emit) begin
      out_valid_nxt               = 1'b1;
      out_data_nxt.handshake      = job_r.hs;
      out_data_nxt.toggle_action  = job_r.tog;
      out_data_nxt.packet_length  = job_r.plen;
      out_data_nxt.data_byte      = byte_val;
      out_data_nxt.last           = emit_last;
      out_data_nxt.address_value  = job_r.addr;
      out_data_nxt.address_write  = job_r.addr_wr;
      out_data_nxt.config_value   = job_r.cfg;
      out_data_nxt.halt_endpoint  = job_r.h_ep;
      out_data_nxt.halt_direction = job_r.h_dir;
      out_data_nxt.halt_action    = job_r.h_act;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
      k_r         <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      job_valid_r <= job_valid_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r      <= job_nxt;
    out_data_r <= out_data_nxt;
  end

  // checks
  `UCER_ASSERT_IMP(a_in_only_when_free, clk, rst_n, in_ch.valid && in_ch.ready, !job_valid_r || emit_last, "transaction taken while job busy")
  `UCER_ASSERT_IMP(a_plen_range, clk, rst_n, out_valid_r, out_data_r.packet_length <= 4'd8, "packet length above eight")
  `UCER_ASSERT_NEXT(a_emit_loads_out, clk, rst_n, emit, out_valid_r, "emitted result not held")
  `UCER_ASSERT_IMP(a_addr_nak, clk, rst_n, out_valid_r && out_data_r.address_write, out_data_r.handshake == HS_NAK, "address load without nak")

endmodule

/* sim/ucer_response_checker.sv */
module ucer_response_checker
  import ucer_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_ready,
  input  ucer_in_t in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  ucer_out_t out_data,
  output int        fail_count,
  output int        pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PKT = 8;

  // responder state mirror
  logic [7:0]  cur_request;
  logic [15:0] bytes_left;
  logic [7:0]  rom_pos;
  logic [6:0]  saved_address;
  logic [7:0]  cur_config;

  ucer_out_t expected_answers[$];

  function automatic logic [7:0] table_byte(input logic [7:0] pos);
    if (int'(pos) >= DESC_TABLE_BYTES || int'(pos) >= DESCRIPTOR_ROM_BYTES_DEF) return 8'h00;
    return DESC_TABLE[pos];
  endfunction

  // load next descriptor chunk
  task automatic take_chunk(ref logic [7:0] buf_q[8], ref int n);
    n = (bytes_left >= PKT) ? PKT : int'(bytes_left);
    for (int i = 0; i < n; i++) buf_q[i] = table_byte(8'(rom_pos + i));
    bytes_left = bytes_left - 16'(n);
    rom_pos = 8'(rom_pos + n);
  endtask

  // endpoint index check for halt requests
  function automatic bit halt_target(input logic [7:0] idx, inout ucer_out_t a,
                                     input logic [1:0] act);
    logic [6:0] ep;
    ep = idx[6:0];
    if (idx[6:4] != 0 || ep < 1 || ep > 3) return 0;
    a.halt_endpoint = ep[1:0];
    a.halt_direction = idx[7];
    a.halt_action = act;
    return 1;
  endfunction

  task automatic predict_event(input ucer_in_t t);
    ucer_out_t a;
    logic [7:0] buf_q[8];
    int n;
    bit stall;
    logic [7:0] off, dlen;
    int count;
    a = '0;
    n = 0;
    stall = 0;
    off = 0;
    dlen = 0;
    foreach (buf_q[i]) buf_q[i] = 8'h00;
    case (t.command)
      CMD_SETUP: begin
        if (t.rx_length != 7'd8) begin
          stall = 1;
        end else begin
          bytes_left = t.length_requested;
          cur_request = t.request_code;
          if (t.request_type[6:5] != 0) begin
            stall = (t.request_code != REQ_SET_REPORT);
          end else begin
            case (t.request_code)
              REQ_GET_DESC: begin
                case (t.value_high)
                  DT_DEVICE: begin off = OFF_DEV; dlen = LEN_DEV; end
                  DT_CONFIG: begin off = OFF_CFG; dlen = LEN_CFG; end
                  DT_REPORT: begin off = OFF_REP; dlen = LEN_REP; end
                  DT_STRING: begin
                    if (t.value_low == 0) begin off = OFF_LANG; dlen = LEN_LANG; end
                    else if (t.value_low == 1) begin off = OFF_MANUF; dlen = LEN_MANUF; end
                    else if (t.value_low == 2) begin off = OFF_PROD; dlen = LEN_PROD; end
                    else begin off = OFF_SER; dlen = LEN_SER; end
                  end
                  default: stall = 1;
                endcase
                if (!stall) begin
                  if (bytes_left > dlen) bytes_left = 16'(dlen);
                  rom_pos = off;
                  take_chunk(buf_q, n);
                end
              end
              REQ_SET_ADDRESS: saved_address = t.value_low[6:0];
              REQ_GET_CONFIG: begin
                buf_q[0] = cur_config;
                n = (bytes_left >= 1) ? 1 : 0;
              end
              REQ_SET_CONFIG: cur_config = t.value_low;
              REQ_GET_INTERFACE: n = 0;
              REQ_CLEAR_FEATURE: begin
                if (t.request_type[4:0] == 5'd2)
                  stall = !halt_target(t.index_low, a, HALT_CLEAR);
                else
                  stall = 1;
              end
              REQ_SET_FEATURE: begin
                if (t.request_type[4:0] == 5'd2 && t.value_low == 0 &&
                    t.value_high == 0 && t.index_high == 0)
                  stall = !halt_target(t.index_low, a, HALT_SET);
                else
                  stall = 1;
              end
              REQ_GET_STATUS: n = (bytes_left >= 2) ? 2 : int'(bytes_left);
              default: stall = 1;
            endcase
          end
        end
        if (stall) begin
          cur_request = REQ_STALLED;
          a = '0;
          foreach (buf_q[i]) buf_q[i] = 8'h00;
          n = 0;
          a.handshake = HS_STALL;
        end
        a.toggle_action = TOG_DATA1;
      end
      CMD_IN: begin
        if (cur_request == REQ_GET_DESC) begin
          take_chunk(buf_q, n);
          a.toggle_action = TOG_FLIP;
        end else if (cur_request == REQ_SET_ADDRESS) begin
          a.address_value = saved_address;
          a.address_write = 1;
          a.handshake = HS_NAK;
        end else begin
          a.handshake = HS_NAK;
        end
      end
      CMD_RESET: begin
        cur_config = 0;
        a.address_write = 1;
        a.handshake = HS_NAK;
      end
      default: ;
    endcase
    a.packet_length = 4'(n);
    a.config_value = cur_config;
    count = (n != 0) ? n : 1;
    for (int k = 0; k < count; k++) begin
      a.data_byte = buf_q[k];
      a.last = (k == count - 1);
      expected_answers.push_back(a);
    end
  endtask

  // watch both channels
  always @(posedge clk) begin
    ucer_out_t e;
    if (!rst_n) begin
      bytes_left = 0;
      rom_pos = 0;
      saved_address = 0;
      cur_config = 0;
      cur_request = 0;
      expected_answers.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_answers.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result %p", out_data);
        end else begin
          e = expected_answers.pop_front();
          if (out_data !== e) begin
            fail_count++;
            if (fail_count <= 10) $display("mismatch: expected %p actual %p", e, out_data);
          end
        end
      end
      if (in_valid && in_ready) predict_event(in_data);
    end
    pending_count = expected_answers.size();
  end

  initial begin
    fail_count = 0;
    pending_count = 0;
  end
endmodule

/* sim/testbench.sv */
module testbench;
  import ucer_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int InBits = $bits(ucer_in_t);

  logic clk = 0;
  logic rst_n = 0;
  int   fail_count, pending_count;
  bit   hold_receiver = 0;
  bit   stim_done = 0;

  ucer_in_if  in_ch();
  ucer_out_if out_ch();

  usb_control_endpoint_responder DUT (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  ucer_response_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data),
    .fail_count(fail_count), .pending_count(pending_count));

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  function automatic int gap_len();
    if ($urandom_range(0, 9) < 6) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  function automatic ucer_in_t setup_item(input logic [7:0] rt, input logic [7:0] code,
                                          input logic [7:0] vl, input logic [7:0] vh,
                                          input logic [7:0] il, input logic [15:0] wl);
    ucer_in_t t;
    t = '0;
    t.command = CMD_SETUP;
    t.rx_length = 7'd8;
    t.toggle_ok = 1'($urandom_range(0, 1));
    t.request_type = rt;
    t.request_code = code;
    t.value_low = vl;
    t.value_high = vh;
    t.index_low = il;
    t.index_high = 0;
    t.length_requested = wl;
    return t;
  endfunction

  function automatic ucer_in_t event_item(input logic [1:0] cmd);
    ucer_in_t t;
    t = ucer_in_t'(InBits'({$urandom, $urandom, $urandom}));
    t.command = cmd;
    return t;
  endfunction

  function automatic ucer_in_t noise_item();
    ucer_in_t t;
    t = ucer_in_t'(InBits'({$urandom, $urandom, $urandom}));
    if ($urandom_range(0, 1)) t.rx_length = 7'($urandom_range(0, 64));
    return t;
  endfunction

  // one transaction, then a random gap
  task automatic send(input ucer_in_t t);
    int g;
    in_ch.valid <= 1;
    in_ch.data <= t;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    g = gap_len();
    if (g > 0) begin
      in_ch.valid <= 0;
      repeat (g) @(negedge clk);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 0;
    while (pending_count != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  function automatic ucer_in_t random_setup();
    logic [7:0] codes[10] = '{REQ_GET_STATUS, REQ_CLEAR_FEATURE, REQ_SET_FEATURE,
      REQ_SET_ADDRESS, REQ_GET_DESC, REQ_GET_CONFIG, REQ_SET_CONFIG,
      REQ_GET_INTERFACE, REQ_GET_DESC, REQ_GET_DESC};
    logic [7:0] types[5] = '{DT_DEVICE, DT_CONFIG, DT_STRING, DT_REPORT, 8'h00};
    ucer_in_t t;
    t = setup_item(8'h00, codes[$urandom_range(0, 9)], 8'($urandom_range(0, 4)),
                   types[$urandom_range(0, 4)], 8'h00, 16'($urandom_range(0, 70)));
    if ($urandom_range(0, 3) == 0) t.length_requested = 16'($urandom);
    if (t.request_code inside {REQ_CLEAR_FEATURE, REQ_SET_FEATURE}) begin
      t.request_type = 8'h02;
      t.value_low = 0;
      t.value_high = 0;
      t.index_low = {1'($urandom), 3'b000, 4'($urandom_range(0, 4))};
    end
    if (t.request_code == REQ_SET_CONFIG || t.request_code == REQ_SET_ADDRESS)
      t.value_low = 8'($urandom);
    if ($urandom_range(0, 7) == 0) t.request_type = 8'($urandom);
    return t;
  endfunction

  // receiver side
  initial begin
    out_ch.ready = 0;
    forever begin
      @(negedge clk);
      if (hold_receiver) out_ch.ready <= 0;
      else if ($urandom_range(0, 9) < 7) out_ch.ready <= 1;
      else begin
        out_ch.ready <= 0;
        repeat (gap_len()) @(negedge clk);
      end
    end
  end

  // long receiver stall while the sender keeps offering
  initial begin
    wait (stim_done == 0 && rst_n);
    repeat (400) @(negedge clk);
    hold_receiver = 1;
    repeat (60) @(negedge clk);
    hold_receiver = 0;
  end

  initial begin
    in_ch.valid = 0;
    in_ch.data = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);
    // directed part
    send(setup_item(8'h80, REQ_GET_DESC, 0, DT_DEVICE, 0, 16'hFFFF));
    repeat (3) send(event_item(CMD_IN));
    send(setup_item(8'h80, REQ_GET_DESC, 0, DT_CONFIG, 0, 16'd9));
    repeat (2) send(event_item(CMD_IN));
    send(setup_item(8'h80, REQ_GET_DESC, 0, DT_REPORT, 0, 16'd40));
    send(setup_item(8'h80, REQ_GET_DESC, 8'hFF, DT_STRING, 0, 16'd64));
    send(setup_item(8'h80, REQ_GET_DESC, 0, 8'h07, 0, 16'd64));
    send(setup_item(8'h00, REQ_SET_ADDRESS, 8'hFF, 0, 0, 0));
    repeat (2) send(event_item(CMD_IN));
    send(setup_item(8'h00, REQ_SET_CONFIG, 8'hFF, 0, 0, 0));
    send(setup_item(8'h80, REQ_GET_CONFIG, 0, 0, 0, 16'd1));
    send(setup_item(8'h80, REQ_GET_STATUS, 0, 0, 0, 16'd1));
    send(setup_item(8'h81, REQ_GET_INTERFACE, 0, 0, 0, 16'd1));
    send(setup_item(8'h02, REQ_SET_FEATURE, 0, 0, 8'h81, 0));
    send(setup_item(8'h02, REQ_CLEAR_FEATURE, 0, 0, 8'h03, 0));
    send(setup_item(8'h02, REQ_CLEAR_FEATURE, 0, 0, 8'h04, 0));
    send(setup_item(8'h00, REQ_SET_FEATURE, 1, 0, 0, 0));
    send(setup_item(8'h21, REQ_SET_REPORT, 0, 2, 0, 16'd8));
    send(setup_item(8'hA1, 8'h01, 0, 0, 0, 0));
    send(event_item(CMD_OUT));
    send(event_item(CMD_RESET));
    // sender pause until all results are in
    drain();
    // random part: mostly setups with their INs and OUTs, plus noise items and bus resets
    for (int i = 0; i < 40; i++) begin
      int r;
      r = $urandom_range(0, 9);
      if (r < 7) begin
        send(random_setup());
        repeat ($urandom_range(0, 4)) send(event_item(CMD_IN));
        if ($urandom_range(0, 2) == 0) send(event_item(CMD_OUT));
      end else if (r < 9) begin
        send(noise_item());
      end else begin
        send(event_item(CMD_RESET));
      end
    end
    stim_done = 1;
    in_ch.valid <= 0;
    while (pending_count != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin
    #5ms;
    $display("Verification failed");
    $finish;
  end
endmodule
